// ----- rtl/i2cram_pkg.sv -----
// Package for the I2C register access master: codes, phases and the structs
// passed between the front queue and the bus sequencer. No dependencies.
package i2cram_pkg;

  localparam int unsigned MAX_LEN = 16;
  localparam int unsigned BUF_AW  = 4;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_GAP  = 5'd1,
    PH_ST0  = 5'd2,
    PH_ST1  = 5'd3,
    PH_ST2  = 5'd4,
    PH_RS0  = 5'd5,
    PH_RS1  = 5'd6,
    PH_RS2  = 5'd7,
    PH_RS3  = 5'd8,
    PH_TXL  = 5'd9,
    PH_TXH  = 5'd10,
    PH_AKL  = 5'd11,
    PH_AKH  = 5'd12,
    PH_RXL  = 5'd13,
    PH_RXH  = 5'd14,
    PH_MAL  = 5'd15,
    PH_MAH  = 5'd16,
    PH_SP0  = 5'd17,
    PH_SP1  = 5'd18,
    PH_SP2  = 5'd19
  } phase_t;

  typedef enum logic [1:0] {
    STG_ADDR  = 2'd0,
    STG_REG   = 2'd1,
    STG_DATA  = 2'd2,
    STG_RADDR = 2'd3
  } stage_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BUS_BUSY  = 2'd1;
  localparam logic [1:0] ST_ADDR_NACK = 2'd2;
  localparam logic [1:0] ST_DATA_NACK = 2'd3;

  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd1;
  localparam logic [1:0] CFG_RETRY_GAP   = 2'd2;

  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd50;
  localparam logic [3:0]  RETRY_LIMIT_RST = 4'd1;
  localparam logic [15:0] RETRY_GAP_RST   = 16'd1000;

  typedef struct packed {
    op_t        op;
    logic       sda_sample;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [4:0] length;
    logic       is_read;
    logic [3:0] buf_index;
    logic [7:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic [7:0] read_data;
    logic       read_valid;
    logic [3:0] read_index;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_wr_t;

endpackage

// ----- rtl/i2cram_front.sv -----
// Front end: accepts input requests, classifies them into commands and holds
// them in a two-entry queue for the sequencer. Depends on i2cram_pkg.
module i2cram_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [39:0]         in_tdata,
  input  logic [1:0]          in_tuser,
  output logic                q_valid,
  output i2cram_pkg::cmd_t    q_cmd,
  input  logic                q_pop
);
  import i2cram_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  cmd_t       cmd_in;
  logic       push;

  always_comb begin
    cmd_in.op         = op_t'(in_tuser);
    cmd_in.sda_sample = in_tdata[0];
    cmd_in.dev_addr   = in_tdata[7:1];
    cmd_in.reg_addr   = in_tdata[15:8];
    cmd_in.length     = (in_tdata[20:16] > 5'(MAX_LEN)) ? 5'(MAX_LEN) : in_tdata[20:16];
    cmd_in.is_read    = in_tdata[21];
    cmd_in.buf_index  = in_tdata[25:22];
    cmd_in.data_byte  = in_tdata[33:26];
  end

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != 2'd0);
  assign q_cmd     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = (q_pop && q_valid) ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ----- rtl/i2cram_back.sv -----
// Back end: the bus sequencer, write buffer, configuration registers and the
// output result register. Depends on i2cram_pkg.
module i2cram_back (
  input  logic                clk,
  input  logic                rst_n,
  input  i2cram_pkg::cfg_wr_t cfg_wr,
  input  logic                q_valid,
  input  i2cram_pkg::cmd_t    q_cmd,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output i2cram_pkg::res_t    out_res
);
  import i2cram_pkg::*;

  logic [7:0]  ack_timeout_r;
  logic [3:0]  retry_limit_r;
  logic [15:0] retry_gap_r;

  phase_t      phase_r, phase_nxt;
  stage_t      stage_r, stage_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [4:0]  byte_r, byte_nxt;
  logic [3:0]  attempt_r, attempt_nxt;
  logic [1:0]  end_st_r, end_st_nxt;
  logic [6:0]  req_addr_r, req_addr_nxt;
  logic [7:0]  req_reg_r, req_reg_nxt;
  logic [4:0]  req_len_r, req_len_nxt;
  logic        req_read_r, req_read_nxt;
  logic [7:0]  wbuf_r [MAX_LEN];

  res_t        res;
  res_t        res_r;
  logic        res_valid_r;

  always_comb begin
    logic        fail_v;
    logic [1:0]  fail_st_v;
    logic        ack_v;
    logic        ack_ok_v;
    logic [4:0]  bc_v;
    logic [3:0]  att_v;
    logic [3:0]  limit_v;
    logic [15:0] tinc_v;
    logic        more_v;

    phase_nxt    = phase_r;
    stage_nxt    = stage_r;
    tick_nxt     = tick_r;
    bit_nxt      = bit_r;
    shift_nxt    = shift_r;
    byte_nxt     = byte_r;
    attempt_nxt  = attempt_r;
    end_st_nxt   = end_st_r;
    req_addr_nxt = req_addr_r;
    req_reg_nxt  = req_reg_r;
    req_len_nxt  = req_len_r;
    req_read_nxt = req_read_r;
    fail_v       = 1'b0;
    fail_st_v    = ST_OK;
    ack_v        = 1'b0;
    ack_ok_v     = 1'b0;
    tinc_v       = tick_r + 16'd1;
    more_v       = ({1'b0, byte_r} + 6'd1) < {1'b0, req_len_r};

    res             = '0;
    res.scl_level   = 1'b1;
    res.sda_release = 1'b1;

    unique case (q_cmd.op)
      OP_BEGIN: begin
        if (phase_r == PH_IDLE) begin
          req_addr_nxt = q_cmd.dev_addr;
          req_reg_nxt  = q_cmd.reg_addr;
          req_len_nxt  = q_cmd.length;
          req_read_nxt = q_cmd.is_read;
          attempt_nxt  = 4'd0;
          byte_nxt     = 5'd0;
          phase_nxt    = PH_ST0;
        end
      end
      OP_LOAD, OP_NOP: begin
      end
      OP_TICK: begin
        unique case (phase_r)
          PH_IDLE: begin
          end
          PH_GAP: begin
            tick_nxt = tinc_v;
            if (tinc_v >= retry_gap_r) phase_nxt = PH_ST0;
          end
          PH_ST0: begin
            if (!q_cmd.sda_sample) begin
              fail_v    = 1'b1;
              fail_st_v = ST_BUS_BUSY;
            end else begin
              phase_nxt = PH_ST1;
            end
          end
          PH_ST1: begin
            res.sda_release = 1'b0;
            if (q_cmd.sda_sample) begin
              fail_v    = 1'b1;
              fail_st_v = ST_BUS_BUSY;
            end else begin
              phase_nxt = PH_ST2;
            end
          end
          PH_ST2: begin
            res.scl_level   = 1'b0;
            res.sda_release = 1'b0;
            byte_nxt  = 5'd0;
            shift_nxt = {req_addr_r, 1'b0};
            bit_nxt   = 3'd0;
            stage_nxt = STG_ADDR;
            phase_nxt = PH_TXL;
          end
          PH_RS0: begin
            res.scl_level = 1'b0;
            phase_nxt = PH_RS1;
          end
          PH_RS1: phase_nxt = PH_RS2;
          PH_RS2: begin
            res.sda_release = 1'b0;
            phase_nxt = PH_RS3;
          end
          PH_RS3: begin
            res.scl_level   = 1'b0;
            res.sda_release = 1'b0;
            shift_nxt = {req_addr_r, 1'b1};
            bit_nxt   = 3'd0;
            stage_nxt = STG_RADDR;
            phase_nxt = PH_TXL;
          end
          PH_TXL: begin
            res.scl_level   = 1'b0;
            res.sda_release = shift_r[7];
            phase_nxt = PH_TXH;
          end
          PH_TXH: begin
            res.sda_release = shift_r[7];
            shift_nxt = {shift_r[6:0], 1'b0};
            bit_nxt   = bit_r + 3'd1;
            phase_nxt = (bit_r == 3'd7) ? PH_AKL : PH_TXL;
          end
          PH_AKL: begin
            res.scl_level = 1'b0;
            tick_nxt  = 16'd0;
            phase_nxt = PH_AKH;
          end
          PH_AKH: begin
            if (!q_cmd.sda_sample) begin
              ack_v    = 1'b1;
              ack_ok_v = 1'b1;
            end else begin
              tick_nxt = tinc_v;
              if (tinc_v > {8'd0, ack_timeout_r}) ack_v = 1'b1;
            end
          end
          PH_RXL: begin
            res.scl_level = 1'b0;
            phase_nxt = PH_RXH;
          end
          PH_RXH: begin
            shift_nxt = {shift_r[6:0], q_cmd.sda_sample};
            bit_nxt   = bit_r + 3'd1;
            if (bit_r == 3'd7) begin
              res.read_valid = 1'b1;
              res.read_data  = {shift_r[6:0], q_cmd.sda_sample};
              res.read_index = byte_r[3:0];
              phase_nxt = PH_MAL;
            end else begin
              phase_nxt = PH_RXL;
            end
          end
          PH_MAL: begin
            res.scl_level   = 1'b0;
            res.sda_release = !more_v;
            phase_nxt = PH_MAH;
          end
          PH_MAH: begin
            res.sda_release = !more_v;
            byte_nxt = byte_r + 5'd1;
            if (more_v) begin
              bit_nxt   = 3'd0;
              phase_nxt = PH_RXL;
            end else begin
              end_st_nxt = ST_OK;
              phase_nxt  = PH_SP0;
            end
          end
          PH_SP0: begin
            res.scl_level   = 1'b0;
            res.sda_release = 1'b0;
            phase_nxt = PH_SP1;
          end
          PH_SP1: begin
            res.sda_release = 1'b0;
            phase_nxt = PH_SP2;
          end
          PH_SP2: begin
            if (end_st_r == ST_ADDR_NACK) begin
              fail_v    = 1'b1;
              fail_st_v = ST_ADDR_NACK;
            end else begin
              phase_nxt    = PH_IDLE;
              res.done_res = 1'b1;
              res.status   = end_st_r;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
      default: begin
      end
    endcase

    if (ack_v) begin
      bc_v = (stage_r == STG_DATA) ? byte_r + 5'd1 : byte_r;
      case (stage_r)
        STG_ADDR: begin
          if (ack_ok_v) begin
            shift_nxt = req_reg_r;
            bit_nxt   = 3'd0;
            stage_nxt = STG_REG;
            phase_nxt = PH_TXL;
          end else begin
            end_st_nxt = ST_ADDR_NACK;
            phase_nxt  = PH_SP0;
          end
        end
        STG_RADDR: begin
          if (req_len_r != 5'd0) begin
            bit_nxt   = 3'd0;
            shift_nxt = 8'd0;
            phase_nxt = PH_RXL;
          end else begin
            end_st_nxt = ST_OK;
            phase_nxt  = PH_SP0;
          end
        end
        default: begin
          if (stage_r == STG_REG && req_read_r) begin
            phase_nxt = PH_RS0;
          end else if (stage_r == STG_DATA && !ack_ok_v) begin
            end_st_nxt = ST_DATA_NACK;
            phase_nxt  = PH_SP0;
          end else begin
            byte_nxt = bc_v;
            if (bc_v < req_len_r && bc_v < 5'(MAX_LEN)) begin
              shift_nxt = wbuf_r[bc_v[BUF_AW-1:0]];
              bit_nxt   = 3'd0;
              stage_nxt = STG_DATA;
              phase_nxt = PH_TXL;
            end else begin
              end_st_nxt = ST_OK;
              phase_nxt  = PH_SP0;
            end
          end
        end
      endcase
    end

    if (fail_v) begin
      att_v       = attempt_r + 4'd1;
      limit_v     = (retry_limit_r == 4'd0) ? 4'd1 : retry_limit_r;
      attempt_nxt = att_v;
      if (att_v >= limit_v) begin
        phase_nxt    = PH_IDLE;
        res.done_res = 1'b1;
        res.status   = fail_st_v;
      end else if (retry_gap_r == 16'd0) begin
        phase_nxt = PH_ST0;
      end else begin
        tick_nxt  = 16'd0;
        phase_nxt = PH_GAP;
      end
    end

    res.busy_res = (phase_nxt != PH_IDLE);
  end

  assign q_pop      = q_valid && (!res_valid_r || out_tready);
  assign out_tvalid = res_valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= ACK_TIMEOUT_RST;
      retry_limit_r <= RETRY_LIMIT_RST;
      retry_gap_r   <= RETRY_GAP_RST;
      phase_r       <= PH_IDLE;
      stage_r       <= STG_ADDR;
      tick_r        <= 16'd0;
      bit_r         <= 3'd0;
      shift_r       <= 8'd0;
      byte_r        <= 5'd0;
      attempt_r     <= 4'd0;
      end_st_r      <= ST_OK;
      req_addr_r    <= 7'd0;
      req_reg_r     <= 8'd0;
      req_len_r     <= 5'd0;
      req_read_r    <= 1'b0;
      res_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr.valid) begin
        case (cfg_wr.index)
          CFG_ACK_TIMEOUT: ack_timeout_r <= cfg_wr.data[7:0];
          CFG_RETRY_LIMIT: retry_limit_r <= cfg_wr.data[3:0];
          CFG_RETRY_GAP:   retry_gap_r   <= cfg_wr.data;
          default: begin
          end
        endcase
      end
      if (q_pop) begin
        phase_r    <= phase_nxt;
        stage_r    <= stage_nxt;
        tick_r     <= tick_nxt;
        bit_r      <= bit_nxt;
        shift_r    <= shift_nxt;
        byte_r     <= byte_nxt;
        attempt_r  <= attempt_nxt;
        end_st_r   <= end_st_nxt;
        req_addr_r <= req_addr_nxt;
        req_reg_r  <= req_reg_nxt;
        req_len_r  <= req_len_nxt;
        req_read_r <= req_read_nxt;
      end
      if (q_pop) begin
        res_valid_r <= 1'b1;
      end else if (out_tready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res;
    end
    if (q_pop && q_cmd.op == OP_LOAD) begin
      wbuf_r[q_cmd.buf_index] <= q_cmd.data_byte;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.done_res |-> !res_r.busy_res)
    else $error("Completed request still reports busy.");

  a_status_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && (res_r.status != ST_OK) |-> res_r.done_res)
    else $error("Nonzero status without completion.");

  a_read_on_high: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.read_valid |-> res_r.scl_level && res_r.sda_release)
    else $error("Received byte not reported on a released high clock tick.");

  a_attempt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_GAP |-> attempt_r != 4'd0)
    else $error("Retry gap entered without a failed attempt.");

endmodule

// ----- rtl/i2c_register_access_master_unit.sv -----
// Top level of the I2C register access master: front request queue and back
// bus sequencer. Depends on i2cram_pkg, i2cram_front and i2cram_back.
// Latency: with an empty queue, an accepted request passes through a queue slot
// register and then the result register. Throughput: one request per cycle unless
// the output stalls. Reset: synchronous active-low rst_n empties the queue, idles
// the sequencer and restores the register defaults; the write buffer is not cleared.
module i2c_register_access_master_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // sda_sample, dev_addr, reg_addr, length, is_read, buf_index, data_byte
  input  logic [39:0] in_tdata,
  // operation
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // scl_level, sda_release, read_data, read_valid, read_index, busy_res,
  // done_res, status
  output logic [23:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import i2cram_pkg::*;

  logic    q_valid;
  logic    q_pop;
  cmd_t    q_cmd;
  res_t    res;
  cfg_wr_t cfg_wr;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  i2cram_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  i2cram_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_wr),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {5'd0, res.status, res.done_res, res.busy_res, res.read_index,
                      res.read_valid, res.read_data, res.sda_release, res.scl_level};

endmodule

// ----- bench/i2cram_bus_checker.sv -----
// Checker for the I2C register access master: watches the request, result and
// register channels, predicts every result and compares it field by field.
// Depends on i2cram_pkg.
module i2cram_bus_checker
  import i2cram_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  ack_limit;
  logic [3:0]  try_limit;
  logic [15:0] gap_ticks;

  phase_t      phase;
  stage_t      stage;
  logic [15:0] tick_cnt;
  logic [2:0]  bit_cnt;
  logic [7:0]  shifter;
  logic [4:0]  byte_cnt;
  logic [3:0]  attempts;
  logic [6:0]  req_dev;
  logic [7:0]  req_reg;
  logic [4:0]  req_len;
  logic        req_rd;
  logic [1:0]  stop_status;
  logic [7:0]  wbuf [MAX_LEN];
  logic        finished;
  logic [1:0]  finish_status;

  res_t results_due[$];
  res_t want;

  function automatic void send_byte(logic [7:0] b, stage_t stg);
    shifter = b;
    bit_cnt = '0;
    stage = stg;
    phase = PH_TXL;
  endfunction

  function automatic void go_stop(logic [1:0] st);
    stop_status = st;
    phase = PH_SP0;
  endfunction

  function automatic void attempt_lost(logic [1:0] st);
    logic [3:0] lim;
    lim = (try_limit == 4'd0) ? 4'd1 : try_limit;
    attempts = attempts + 4'd1;
    if (attempts >= lim) begin
      phase = PH_IDLE;
      finished = 1'b1;
      finish_status = st;
    end else if (gap_ticks == 16'd0) begin
      phase = PH_ST0;
    end else begin
      tick_cnt = '0;
      phase = PH_GAP;
    end
  endfunction

  function automatic void next_write();
    if (byte_cnt < req_len && byte_cnt < MAX_LEN) begin
      send_byte(wbuf[byte_cnt[3:0]], STG_DATA);
    end else begin
      go_stop(ST_OK);
    end
  endfunction

  function automatic void ack_seen(logic ok);
    case (stage)
      STG_ADDR: begin
        if (ok) send_byte(req_reg, STG_REG);
        else go_stop(ST_ADDR_NACK);
      end
      STG_REG: begin
        if (req_rd) phase = PH_RS0;
        else next_write();
      end
      STG_DATA: begin
        if (!ok) begin
          go_stop(ST_DATA_NACK);
        end else begin
          byte_cnt = byte_cnt + 5'd1;
          next_write();
        end
      end
      default: begin
        if (req_len > 5'd0) begin
          bit_cnt = '0;
          shifter = '0;
          phase = PH_RXL;
        end else begin
          go_stop(ST_OK);
        end
      end
    endcase
  endfunction

  function automatic res_t step_sequencer(op_t op, logic [39:0] d);
    res_t r;
    logic sda_in;
    r = '0;
    r.scl_level = 1'b1;
    r.sda_release = 1'b1;
    sda_in = d[0];
    finished = 1'b0;
    finish_status = ST_OK;
    case (op)
      OP_BEGIN: begin
        if (phase == PH_IDLE) begin
          req_dev = d[7:1];
          req_reg = d[15:8];
          req_len = (d[20:16] > MAX_LEN) ? 5'(MAX_LEN) : d[20:16];
          req_rd = d[21];
          attempts = '0;
          byte_cnt = '0;
          phase = PH_ST0;
        end
      end
      OP_LOAD: wbuf[d[25:22]] = d[33:26];
      OP_TICK: begin
        case (phase)
          PH_IDLE: ;
          PH_GAP: begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= gap_ticks) phase = PH_ST0;
          end
          PH_ST0: begin
            if (!sda_in) attempt_lost(ST_BUS_BUSY);
            else phase = PH_ST1;
          end
          PH_ST1: begin
            r.sda_release = 1'b0;
            if (sda_in) attempt_lost(ST_BUS_BUSY);
            else phase = PH_ST2;
          end
          PH_ST2: begin
            r.scl_level = 1'b0;
            r.sda_release = 1'b0;
            byte_cnt = '0;
            send_byte({req_dev, 1'b0}, STG_ADDR);
          end
          PH_RS0: begin
            r.scl_level = 1'b0;
            phase = PH_RS1;
          end
          PH_RS1: phase = PH_RS2;
          PH_RS2: begin
            r.sda_release = 1'b0;
            phase = PH_RS3;
          end
          PH_RS3: begin
            r.scl_level = 1'b0;
            r.sda_release = 1'b0;
            send_byte({req_dev, 1'b1}, STG_RADDR);
          end
          PH_TXL: begin
            r.scl_level = 1'b0;
            r.sda_release = shifter[7];
            phase = PH_TXH;
          end
          PH_TXH: begin
            r.sda_release = shifter[7];
            shifter = shifter << 1;
            bit_cnt = bit_cnt + 3'd1;
            phase = (bit_cnt == 3'd0) ? PH_AKL : PH_TXL;
          end
          PH_AKL: begin
            r.scl_level = 1'b0;
            tick_cnt = '0;
            phase = PH_AKH;
          end
          PH_AKH: begin
            if (!sda_in) begin
              ack_seen(1'b1);
            end else begin
              tick_cnt = tick_cnt + 16'd1;
              if (tick_cnt > ack_limit) ack_seen(1'b0);
            end
          end
          PH_RXL: begin
            r.scl_level = 1'b0;
            phase = PH_RXH;
          end
          PH_RXH: begin
            shifter = {shifter[6:0], sda_in};
            bit_cnt = bit_cnt + 3'd1;
            if (bit_cnt == 3'd0) begin
              r.read_valid = 1'b1;
              r.read_data = shifter;
              r.read_index = byte_cnt[3:0];
              phase = PH_MAL;
            end else begin
              phase = PH_RXL;
            end
          end
          PH_MAL: begin
            r.scl_level = 1'b0;
            r.sda_release = (int'(byte_cnt) + 1 < int'(req_len)) ? 1'b0 : 1'b1;
            phase = PH_MAH;
          end
          PH_MAH: begin
            r.sda_release = (int'(byte_cnt) + 1 < int'(req_len)) ? 1'b0 : 1'b1;
            byte_cnt = byte_cnt + 5'd1;
            if (byte_cnt < req_len) begin
              bit_cnt = '0;
              phase = PH_RXL;
            end else begin
              go_stop(ST_OK);
            end
          end
          PH_SP0: begin
            r.scl_level = 1'b0;
            r.sda_release = 1'b0;
            phase = PH_SP1;
          end
          PH_SP1: begin
            r.sda_release = 1'b0;
            phase = PH_SP2;
          end
          PH_SP2: begin
            if (stop_status == ST_ADDR_NACK) begin
              attempt_lost(ST_ADDR_NACK);
            end else begin
              phase = PH_IDLE;
              finished = 1'b1;
              finish_status = stop_status;
            end
          end
          default: phase = PH_IDLE;
        endcase
      end
      default: ;
    endcase
    r.busy_res = (phase != PH_IDLE);
    r.done_res = finished;
    r.status = finish_status;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want_v, got_v);
    if (want_v != got_v) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ack_limit <= ACK_TIMEOUT_RST;
      try_limit <= RETRY_LIMIT_RST;
      gap_ticks <= RETRY_GAP_RST;
      phase = PH_IDLE;
      stage = STG_ADDR;
      tick_cnt = '0;
      bit_cnt = '0;
      shifter = '0;
      byte_cnt = '0;
      attempts = '0;
      req_dev = '0;
      req_reg = '0;
      req_len = '0;
      req_rd = 1'b0;
      stop_status = ST_OK;
      results_due.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ACK_TIMEOUT: ack_limit <= cfg_data[7:0];
          CFG_RETRY_LIMIT: try_limit <= cfg_data[3:0];
          CFG_RETRY_GAP:   gap_ticks <= cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t ns: result with no request outstanding, expected none, got %h",
                   $time, out_tdata);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("scl_level", want.scl_level, out_tdata[0]);
          check_field("sda_release", want.sda_release, out_tdata[1]);
          check_field("read_data", want.read_data, out_tdata[9:2]);
          check_field("read_valid", want.read_valid, out_tdata[10]);
          check_field("read_index", want.read_index, out_tdata[14:11]);
          check_field("busy_res", want.busy_res, out_tdata[15]);
          check_field("done_res", want.done_res, out_tdata[16]);
          check_field("status", want.status, out_tdata[18:17]);
        end
      end
      if (in_tvalid && in_tready) begin
        results_due.push_back(step_sequencer(op_t'(in_tuser), in_tdata));
      end
      pending <= results_due.size();
    end
  end

endmodule

// ----- bench/i2c_register_access_master_unit_test.sv -----
// Top of the I2C register access master bench: clock, reset, request and
// register stimulus, result back-pressure and the verdict.
// Depends on i2cram_pkg, i2c_register_access_master_unit and i2cram_bus_checker.
module i2c_register_access_master_unit_test;
  import i2cram_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int fail_count;
  int pending;
  int got;
  int done_cnt;
  int sent;
  int cyc;
  bit last_busy;
  logic calm;

  i2c_register_access_master_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  i2cram_bus_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;
  assign calm = (cyc >= 2500) && (cyc < 4000);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got <= got + 1;
      last_busy <= out_tdata[15];
      if (out_tdata[16]) done_cnt <= done_cnt + 1;
    end
  end

  // The receiver stalls once for a long stretch so that the request queue fills.
  initial begin
    bit stalled;
    stalled = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!stalled && got >= 200) begin
        stalled = 1'b1;
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      out_tready <= calm || ($urandom_range(99) >= 27);
    end
  end

  function automatic cmd_t tick_cmd(logic s);
    cmd_t c;
    c = '0;
    c.op = OP_TICK;
    c.sda_sample = s;
    return c;
  endfunction

  function automatic cmd_t load_cmd(logic [3:0] idx, logic [7:0] b);
    cmd_t c;
    c = '0;
    c.op = OP_LOAD;
    c.buf_index = idx;
    c.data_byte = b;
    return c;
  endfunction

  function automatic cmd_t begin_cmd(logic [6:0] dev, logic [7:0] rg, logic [4:0] len,
                                     logic rd);
    cmd_t c;
    c = '0;
    c.op = OP_BEGIN;
    c.dev_addr = dev;
    c.reg_addr = rg;
    c.length = len;
    c.is_read = rd;
    return c;
  endfunction

  task automatic push(cmd_t c);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c.op;
    in_tdata <= {6'b0, c.data_byte, c.buf_index, c.is_read, c.length, c.reg_addr,
                 c.dev_addr, c.sda_sample};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic settle();
    drain();
    while (last_busy) begin
      repeat (32) push(tick_cmd($urandom_range(1)));
      drain();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(int to, int lim, int gap);
    settle();
    cfg_write(CFG_ACK_TIMEOUT, to);
    cfg_write(CFG_RETRY_LIMIT, lim);
    cfg_write(CFG_RETRY_GAP, gap);
  endtask

  // Start mode 0 gives a clean start, 1 a busy bus on the first check and 2 on
  // the second. SDA is held low until quiet_end ticks have passed, then it is
  // high pct_high percent of the time.
  task automatic xfer(logic [6:0] dev, logic [7:0] rg, logic [4:0] len, logic rd,
                      int start_mode, int quiet_end, int pct_high, bit meddle);
    int base;
    int i;
    logic s;
    cmd_t c;
    base = done_cnt;
    push(begin_cmd(dev, rg, len, rd));
    i = 0;
    while (done_cnt == base) begin
      if (i == 0) s = (start_mode != 1);
      else if (i == 1) s = (start_mode == 2);
      else if (i < quiet_end) s = 1'b0;
      else s = ($urandom_range(99) < pct_high);
      push(tick_cmd(s));
      if (meddle && i == 4) begin
        push(begin_cmd($urandom_range(127), $urandom_range(255), $urandom_range(31),
                       $urandom_range(1)));
        c = '0;
        c.op = OP_NOP;
        c.dev_addr = 7'h55;
        push(c);
        push(load_cmd($urandom_range(15), $urandom_range(255)));
      end
      i++;
    end
  endtask

  task automatic rand_xfer();
    int r;
    int len;
    int mode;
    int pct;
    r = $urandom_range(99);
    if (r < 70) len = $urandom_range(3);
    else if (r < 95) len = $urandom_range(16, 4);
    else len = $urandom_range(31, 17);
    mode = ($urandom_range(9) < 8) ? 0 : $urandom_range(2, 1);
    pct = ($urandom_range(3) == 0) ? $urandom_range(100, 85) : $urandom_range(60);
    xfer($urandom_range(127), $urandom_range(255), len, $urandom_range(1), mode,
         $urandom_range(60, 2), pct, $urandom_range(7) == 0);
  endtask

  initial begin
    int base;
    int k;
    cmd_t c;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fill every buffer slot before any write transaction can read it.
    for (k = 0; k < MAX_LEN; k++) begin
      push(load_cmd(k, (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : (k == 2) ? 8'h80 :
                       (k == 3) ? 8'h01 : 8'($urandom_range(255))));
    end
    xfer(7'h7F, 8'hFF, 5'd3, 1'b0, 0, 1000, 0, 1'b0);
    xfer(7'h00, 8'h00, 5'd2, 1'b1, 0, 21, 50, 1'b0);
    xfer(7'h2A, 8'h80, 5'd31, 1'b1, 0, 21, 50, 1'b0);
    xfer(7'h15, 8'h5A, 5'd0, 1'b0, 0, 1000, 0, 1'b0);
    xfer(7'h6B, 8'hA5, 5'd0, 1'b1, 0, 1000, 0, 1'b0);
    xfer(7'h11, 8'h22, 5'd1, 1'b0, 1, 1000, 0, 1'b0);
    xfer(7'h12, 8'h23, 5'd1, 1'b1, 2, 1000, 0, 1'b0);
    xfer(7'h40, 8'h01, 5'd2, 1'b0, 0, 2, 100, 1'b0);
    xfer(7'h41, 8'h02, 5'd2, 1'b0, 0, 39, 100, 1'b0);
    xfer(7'h42, 8'h03, 5'd2, 1'b1, 0, 21, 100, 1'b0);
    xfer(7'h43, 8'h04, 5'd2, 1'b0, 0, 21, 100, 1'b0);
    xfer(7'h44, 8'h05, 5'd16, 1'b0, 0, 1000, 0, 1'b1);

    set_regs(1, 15, 0);
    repeat (3) rand_xfer();
    set_regs(255, 3, 5);
    repeat (3) rand_xfer();
    set_regs(50, 2, 16'hFFFF);
    xfer(7'h33, 8'h44, 5'd1, 1'b0, 1, 1000, 30, 1'b0);

    base = sent;
    while (sent - base < 1000) begin
      set_regs(($urandom_range(1) == 0) ? $urandom_range(4, 1) : $urandom_range(255, 1),
               $urandom_range(15, 1), $urandom_range(30));
      repeat (4) rand_xfer();
      repeat (25) begin
        c.op = op_t'($urandom_range(3));
        c.sda_sample = $urandom_range(1);
        c.dev_addr = $urandom_range(127);
        c.reg_addr = $urandom_range(255);
        c.length = $urandom_range(31);
        c.is_read = $urandom_range(1);
        c.buf_index = $urandom_range(15);
        c.data_byte = $urandom_range(255);
        push(c);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    for (k = 0; k < 5000 && pending != 0; k++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/i2cram_pkg.sv
rtl/i2cram_front.sv
rtl/i2cram_back.sv
rtl/i2c_register_access_master_unit.sv
bench/i2cram_bus_checker.sv
bench/i2c_register_access_master_unit_test.sv
